// ===== hw/rtl/lpht_pkg.sv =====
// Package for the linear-probing hash table: operation and status codes,
// hash constants. Used by top level, lpht_hash, checker and testbench.
package lpht_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/lpht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lpht_hash.sv =====
// Byte-serial FNV-1a hash unit, a byte at a time (xor and 32-bit
// partial products, then fold). Latches key and length at start. Uses lpht_pkg.
module lpht_hash #(
  parameter int SLOT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          key,
  input  logic [3:0]           len,
  output logic                 done,
  output logic [SLOT_BITS-1:0] slot
);
  import lpht_pkg::*;

  logic [63:0] h_r, h_nxt;
  logic [63:0] key_r, key_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ph_r, ph_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [40:0] lo_r, lo_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [7:0]  byte_w;
  logic [63:0] x_w;

  // prime = 2^40 + 0x1b3: product = x*0x1b3 + (x << 40)
  assign byte_w = key_r[{cnt_r[2:0], 3'b000} +: 8];
  assign x_w    = h_r ^ {56'd0, byte_w};

  always_comb begin
    h_nxt    = h_r;
    key_nxt  = key_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    if (start) begin
      h_nxt    = FNV_BASIS;
      key_nxt  = key;
      len_nxt  = len;
      cnt_nxt  = '0;
      ph_nxt   = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!ph_r) begin
        if (cnt_r == len_r) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          lo_nxt = x_w[31:0] * 9'h1b3;
          hi_nxt = 32'(x_w[63:32] * 9'h1b3) + {x_w[23:0], 8'd0};
          ph_nxt = 1'b1;
        end
      end else begin
        h_nxt   = {hi_r, 32'd0} + {23'd0, lo_r};
        cnt_nxt = cnt_r + 4'd1;
        ph_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
    end
    h_r   <= h_nxt;
    key_r <= key_nxt;
    len_r <= len_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  assign done = done_r;
  assign slot = h_r[SLOT_BITS-1:0];

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Linear-probing hash table: top level. Uses lpht_pkg, lpht_hash, lpht_ram.
// After reset a clearing pass writes every slot empty, one slot per cycle,
// with in_ready low. Then one request at a time: it is accepted, its key is
// hashed, and each probe is a registered slot memory read, then compare and
// write back; a zero-length or KIND_NONE request goes straight to output.
// A remove then scans forward: each occupied candidate is read, latched and
// rehashed, and moved back into the hole if its home allows; the empty slot
// that ends the scan clears the hole. The result sits in an output register
// until out_ready takes it, and the next request is taken once it is delivered.
module linear_probe_hash_table #(
  parameter int TABLE_SLOTS = 256,
  parameter int VALUE_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [63:0]           in_key_bytes,
  input  logic [3:0]            in_key_len,
  input  logic [31:0]           in_value_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [31:0]           out_value_out,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_fill_limit
);
  import lpht_pkg::*;

  localparam int SB = $clog2(TABLE_SLOTS);
  localparam int CB = SB + 1;
  localparam int EW = 64 + 4 + VALUE_BITS;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_PRD   = 9'b000001000,
    S_PCMP  = 9'b000010000,
    S_SRD   = 9'b000100000,
    S_SCHK  = 9'b001000000,
    S_SHASH = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]  fill_r;
  logic [CB-1:0] count_r, count_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [63:0] key_r, key_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [SB-1:0] idx_r, idx_nxt, hole_r, hole_nxt;
  logic [SB:0]   n_r, n_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [31:0] vo_r, vo_nxt;
  logic [EW-1:0] ent_r, ent_nxt;

  logic          we;
  logic [SB-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          h_start, h_done;
  logic [63:0]   h_key;
  logic [3:0]    h_len;
  logic [SB-1:0] h_slot;
  logic [63:0]   mkey;
  logic [3:0]    mlen;
  logic [63:0]   r_key;
  logic [3:0]    r_len;
  logic [VALUE_BITS-1:0] r_val;

  lpht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  lpht_hash #(.SLOT_BITS(SB)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(h_start), .key(h_key), .len(h_len),
    .done(h_done), .slot(h_slot)
  );

  assign r_key = rdata[EW-1 -: 64];
  assign r_len = rdata[VALUE_BITS +: 4];
  assign r_val = rdata[VALUE_BITS-1:0];

  always_comb begin
    mlen = (in_key_len > 4'd8) ? 4'd8 : in_key_len;
    mkey = in_key_bytes;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= mlen) mkey[b*8 +: 8] = 8'd0;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_value_out = vo_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    kind_nxt = kind_r; key_nxt = key_r; len_nxt = len_r; val_nxt = val_r;
    idx_nxt = idx_r; hole_nxt = hole_r; n_nxt = n_r;
    st_nxt = st_r; vo_nxt = vo_r; ent_nxt = ent_r;
    we = 1'b0; waddr = idx_r; wdata = ent_r; raddr = idx_r;
    h_start = 1'b0; h_key = key_r; h_len = len_r;
    unique case (state_r)
      S_CLR: begin
        we = 1'b1; waddr = idx_r; wdata = '0;
        idx_nxt = idx_r + SB'(1);
        if (idx_r == SB'(TABLE_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind; key_nxt = mkey; len_nxt = mlen;
          val_nxt = VALUE_BITS'(in_value_in);
          st_nxt = ST_MISS; vo_nxt = '0; n_nxt = '0;
          if (mlen == 4'd0 || in_kind == KIND_NONE) begin
            state_nxt = S_OUT;
          end else begin
            h_start = 1'b1; h_key = mkey; h_len = mlen;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (h_done) begin
          idx_nxt = h_slot;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        raddr = idx_r;
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        if (r_len == 4'd0 || n_r == (SB+1)'(TABLE_SLOTS)) begin
          if (kind_r == KIND_INSERT) begin
            if (32'(count_r) >= 32'(fill_r) || count_r + CB'(1) >= CB'(TABLE_SLOTS)
                || r_len != 4'd0) begin
              st_nxt = ST_FULL;
            end else begin
              we = 1'b1; waddr = idx_r; wdata = {key_r, len_r, val_r};
              count_nxt = count_r + CB'(1);
              st_nxt = ST_OK;
            end
          end
          state_nxt = S_OUT;
        end else if (r_len == len_r && r_key == key_r) begin
          if (kind_r == KIND_INSERT) begin
            st_nxt = ST_DUP;
            state_nxt = S_OUT;
          end else begin
            st_nxt = ST_OK;
            vo_nxt = 32'(r_val);
            if (kind_r == KIND_REMOVE) begin
              hole_nxt = idx_r;
              idx_nxt = idx_r + SB'(1);
              n_nxt = '0;
              if (count_r != '0) count_nxt = count_r - CB'(1);
              state_nxt = S_SRD;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end else begin
          idx_nxt = idx_r + SB'(1);
          n_nxt = n_r + (SB+1)'(1);
          state_nxt = S_PRD;
        end
      end
      S_SRD: begin
        raddr = idx_r;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (r_len == 4'd0 || n_r == (SB+1)'(TABLE_SLOTS)) begin
          we = 1'b1; waddr = hole_r; wdata = '0;
          state_nxt = S_OUT;
        end else begin
          ent_nxt = rdata;
          h_start = 1'b1; h_key = r_key; h_len = r_len;
          n_nxt = n_r + (SB+1)'(1);
          state_nxt = S_SHASH;
        end
      end
      S_SHASH: begin
        if (h_done) begin
          if (SB'(idx_r - h_slot) >= SB'(idx_r - hole_r)) begin
            we = 1'b1; waddr = hole_r; wdata = ent_r;
            hole_nxt = idx_r;
          end
          idx_nxt = idx_r + SB'(1);
          state_nxt = S_SRD;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      fill_r  <= 8'd154;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) fill_r <= cfg_fill_limit;
    end
    kind_r <= kind_nxt; key_r <= key_nxt; len_r <= len_nxt; val_r <= val_nxt;
    hole_r <= hole_nxt; n_r <= n_nxt; ent_r <= ent_nxt;
    st_r <= st_nxt; vo_r <= vo_nxt;
  end

endmodule

// ===== hw/rtl/lpht_checker.sv =====
// Port-level checker for linear_probe_hash_table, bound to the top level.
// Uses lpht_pkg for status codes.
module lpht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_value_out
);
  import lpht_pkg::*;

  a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");

  a_vo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_value_out == 32'd0)
    else $error("value on failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_status))
    else $error("result dropped");

  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> in_valid && $stable(in_kind))
    else $error("request withdrawn");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready),
  .out_status(out_status), .out_value_out(out_value_out)
);

// ===== sim/tb_top.sv =====
// Testbench for linear_probe_hash_table: drives insert, lookup, remove and
// KIND_NONE requests, predicts each answer with a behavioural hash table and
// checks every result. Depends on lpht_pkg and the RTL top level only.
module tb_top;
  import lpht_pkg::*;

  localparam int SLOTS = 256;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_LOOKUP;
  logic [63:0] in_key_bytes = '0;
  logic [3:0]  in_key_len = 4'd1;
  logic [31:0] in_value_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_value_out;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_fill_limit = 8'd154;

  logic [63:0] tbl_key [SLOTS];
  logic [3:0]  tbl_len [SLOTS];
  logic [31:0] tbl_val [SLOTS];
  int          occupancy;
  int          fill_lim;

  answer_t     pending_answers[$];
  logic [63:0] live_keys[$];
  logic [3:0]  live_lens[$];
  int          errors;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;

  linear_probe_hash_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_key_bytes(in_key_bytes), .in_key_len(in_key_len), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_value_out(out_value_out), .cfg_we(cfg_we), .cfg_fill_limit(cfg_fill_limit)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] home_of(logic [63:0] bytes, logic [3:0] len);
    logic [63:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      h = (h ^ {56'd0, bytes[8*i +: 8]}) * FNV_PRIME;
    end
    return h[7:0];
  endfunction

  function automatic bit probe(logic [63:0] bytes, logic [3:0] len, output int at);
    int idx;
    idx = home_of(bytes, len);
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_len[idx] == 0) begin
        at = idx;
        return 0;
      end
      if (tbl_len[idx] == len && tbl_key[idx] == bytes) begin
        at = idx;
        return 1;
      end
      idx = (idx + 1) % SLOTS;
    end
    at = idx;
    return 0;
  endfunction

  function automatic void shift_back(int hole);
    int j;
    int k;
    j = hole;
    tbl_len[hole] = 0;
    for (int n = 0; n < SLOTS; n++) begin
      j = (j + 1) % SLOTS;
      if (tbl_len[j] == 0) break;
      k = home_of(tbl_key[j], tbl_len[j]);
      if (((j - k) & (SLOTS - 1)) >= ((j - hole) & (SLOTS - 1))) begin
        tbl_key[hole] = tbl_key[j];
        tbl_len[hole] = tbl_len[j];
        tbl_val[hole] = tbl_val[j];
        tbl_len[j] = 0;
        hole = j;
      end
    end
    if (occupancy > 0) occupancy--;
  endfunction

  function automatic answer_t apply_request(logic [1:0] kind, logic [63:0] bytes,
                                            logic [3:0] len_in, logic [31:0] value);
    answer_t a;
    int at;
    bit hit;
    logic [3:0] len;
    a.status = ST_MISS;
    a.value = '0;
    len = (len_in > 8) ? 4'd8 : len_in;
    if (len < 8) bytes &= (64'd1 << (8 * len)) - 64'd1;
    if (len != 0) begin
      hit = probe(bytes, len, at);
      if (kind == KIND_INSERT) begin
        if (hit) begin
          a.status = ST_DUP;
        end else if (occupancy >= fill_lim || occupancy + 1 >= SLOTS || tbl_len[at] != 0) begin
          a.status = ST_FULL;
        end else begin
          tbl_key[at] = bytes;
          tbl_len[at] = len;
          tbl_val[at] = value;
          occupancy++;
          a.status = ST_OK;
          live_keys.push_back(bytes);
          live_lens.push_back(len);
        end
      end else if ((kind == KIND_LOOKUP || kind == KIND_REMOVE) && hit) begin
        a.value = tbl_val[at];
        a.status = ST_OK;
        if (kind == KIND_REMOVE) shift_back(at);
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_request(logic [1:0] kind, logic [63:0] bytes, logic [3:0] len,
                              logic [31:0] value);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pending_answers.push_back(apply_request(kind, bytes, len, value));
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key_bytes <= bytes;
    in_key_len <= len;
    in_value_in <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_fill_limit(int lim);
    drain();
    fill_lim = lim;
    cfg_we <= 1'b1;
    cfg_fill_limit <= lim[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [3:0] small_key_len();
    return 4'($urandom_range(1, 2));
  endfunction

  task automatic send_mixed(int count, int pool);
    int pick;
    int r;
    logic [3:0] len;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_request(2'($urandom_range(3)), rand_key(), 4'($urandom()), $urandom());
      end else if (r < 45 || live_keys.size() == 0) begin
        len = (pool != 0) ? small_key_len() : 4'($urandom_range(1, 8));
        send_request(KIND_INSERT, rand_key(), len, $urandom());
      end else begin
        pick = $urandom_range(live_keys.size() - 1);
        send_request((r < 70) ? KIND_LOOKUP : (r < 90 ? KIND_REMOVE : KIND_INSERT),
                     live_keys[pick] | (rand_key() << (8 * live_lens[pick])),
                     live_lens[pick], $urandom());
        if (r >= 70 && r < 90) begin
          live_keys.delete(pick);
          live_lens.delete(pick);
        end
      end
    end
  endtask

  task automatic test_directed();
    send_request(KIND_LOOKUP, '0, 4'd1, '0);
    send_request(KIND_INSERT, 64'hffff_ffff_ffff_ffff, 4'd8, 32'hffff_ffff);
    send_request(KIND_INSERT, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h1234);
    send_request(KIND_LOOKUP, 64'hffff_ffff_ffff_ffff, 4'd15, '0);
    send_request(KIND_INSERT, '0, 4'd1, '0);
    send_request(KIND_LOOKUP, 64'hdead_beef_0000_0000, 4'd1, '0);
    send_request(KIND_INSERT, 64'h55, 4'd0, 32'h5);
    send_request(KIND_NONE, 64'h0, 4'd1, '0);
    send_request(KIND_REMOVE, 64'hffff_ffff_ffff_ffff, 4'd8, '0);
    send_request(KIND_REMOVE, 64'hffff_ffff_ffff_ffff, 4'd8, '0);
    send_request(KIND_INSERT, 64'h0102, 4'd2, 32'haaaa_5555);
    send_request(KIND_LOOKUP, 64'h0102, 4'd3, '0);
    send_request(KIND_REMOVE, '0, 4'd1, '0);
  endtask

  task automatic test_fill_limits();
    set_fill_limit(1);
    send_request(KIND_INSERT, 64'h77, 4'd1, 32'h7);
    send_request(KIND_INSERT, 64'h0102, 4'd2, 32'h9);
    send_request(KIND_LOOKUP, 64'h77, 4'd1, '0);
    set_fill_limit(0);
    send_request(KIND_INSERT, 64'h99, 4'd1, 32'h9);
    set_fill_limit(255);
    send_mixed(300, 1);
  endtask

  task automatic test_random();
    set_fill_limit(40);
    send_mixed(200, 0);
    send_idle_pct = 47;
    send_mixed(150, 1);
    send_idle_pct = 0;
    recv_stall_pct = 47;
    set_fill_limit(154);
    send_mixed(150, 0);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    send_mixed(150, 1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 300;
    send_mixed(20, 1);
    drain();
    set_fill_limit(200);
    send_mixed(150, 1);
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, out_status}, '0);
        end else begin
          want = pending_answers.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_value_out !== want.value) report_mismatch("value", out_value_out, want.value);
        end
      end
      out_ready <= (hold_cycles <= 1) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    errors = 0;
    occupancy = 0;
    fill_lim = 154;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    for (int i = 0; i < SLOTS; i++) tbl_len[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_limits();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
